>>> design/rmq_pkg.sv
// shared definitions for the rotation matrix to quaternion unit
// no dependencies
package rmq_pkg;

  localparam int unsigned DefDataWidth = 16;
  localparam int unsigned DefFracBits  = 14;

  typedef enum logic [1:0] {
    BR_X = 2'd0,
    BR_Y = 2'd1,
    BR_Z = 2'd2
  } rmq_branch_e;

endpackage

>>> design/rmq_root_step.sv
// one digit step of the restoring integer square root
// no dependencies; instantiated once per root bit by the top level
module rmq_root_step #(
  parameter int unsigned RootW = 16,
  parameter int unsigned NW    = 32
) (
  input  logic [RootW:0]   rem_i,
  input  logic [RootW-1:0] root_i,
  input  logic [NW-1:0]    src_i,
  output logic [RootW:0]   rem_o,
  output logic [RootW-1:0] root_o,
  output logic [NW-1:0]    src_o
);

  logic [RootW+2:0] rem_x;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;
  logic             ge;

  always_comb begin
    rem_x  = {rem_i, src_i[NW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (rem_x >= trial);
    diff   = rem_x - trial;
    rem_o  = ge ? diff[RootW:0] : rem_x[RootW:0];
    root_o = {root_i[RootW-2:0], ge};
    src_o  = {src_i[NW-3:0], 2'b00};
  end

endmodule

>>> design/rmq_div_step.sv
// one quotient bit of the restoring unsigned divider
// no dependencies; instantiated per quotient bit and per divider by the top level
module rmq_div_step #(
  parameter int unsigned SW = 17,
  parameter int unsigned QB = 17
) (
  input  logic [SW-1:0] rem_i,
  input  logic [QB-1:0] lo_i,
  input  logic [QB-1:0] quo_i,
  input  logic [SW-1:0] den_i,
  output logic [SW-1:0] rem_o,
  output logic [QB-1:0] lo_o,
  output logic [QB-1:0] quo_o
);

  logic [SW:0] rem_x;
  logic [SW:0] diff;
  logic        ge;

  always_comb begin
    rem_x = {rem_i, lo_i[QB-1]};
    ge    = (rem_x >= {1'b0, den_i});
    diff  = rem_x - {1'b0, den_i};
    rem_o = ge ? diff[SW-1:0] : rem_x[SW-1:0];
    quo_o = {quo_i[QB-2:0], ge};
    lo_o  = {lo_i[QB-2:0], 1'b0};
  end

endmodule

>>> design/rotation_matrix_to_quaternion_unit.sv
// Converts matrix rotation into a quaternion, one transaction per cycle unless stalled.
// The unit is a single pipeline of RootW + DATA_WIDTH + 6 register stages, where RootW is
// half the radicand width: the square root produces one root bit per stage and the three
// dividers one quotient bit per stage each. A new matrix is taken in every cycle while
// in_stall_o is low; a stalled output only holds the stages behind it once they are all
// full, and empty stages close up under a stall.
// Depends on rmq_pkg, rmq_root_step and rmq_div_step.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DefDataWidth,
  parameter int unsigned FRAC_BITS  = DefFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] r0c0_i,
  input  logic signed [DATA_WIDTH-1:0] r1c0_i,
  input  logic signed [DATA_WIDTH-1:0] r2c0_i,
  input  logic signed [DATA_WIDTH-1:0] r0c1_i,
  input  logic signed [DATA_WIDTH-1:0] r1c1_i,
  input  logic signed [DATA_WIDTH-1:0] r2c1_i,
  input  logic signed [DATA_WIDTH-1:0] r0c2_i,
  input  logic signed [DATA_WIDTH-1:0] r1c2_i,
  input  logic signed [DATA_WIDTH-1:0] r2c2_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o,
  output logic signed [DATA_WIDTH-1:0] quat_w_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned FB    = FRAC_BITS;
  localparam int unsigned MW    = (DW > FB + 1) ? DW : FB + 1;
  localparam int unsigned RW    = MW + 2;
  localparam int unsigned NU    = RW - 1 + FB;
  localparam int unsigned NW    = NU + (NU % 2);
  localparam int unsigned RootW = NW / 2;
  localparam int unsigned SW    = (RootW + 1 > FB + 1) ? RootW + 1 : FB + 1;
  localparam int unsigned QB    = DW + 1;
  localparam int unsigned DDW   = QB + FB;

  localparam int unsigned Prep = RootW + 1;
  localparam int unsigned DivL = RootW + 1 + QB;
  localparam int unsigned SatS = DivL + 1;
  localparam int unsigned SqS  = DivL + 2;
  localparam int unsigned Fin  = DivL + 3;
  localparam int unsigned L    = DivL + 4;

  localparam longint          MaxL   = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam longint          OneL   = 64'sd1 <<< FB;
  localparam longint unsigned Small  = ((64'd1 << FB) + 64'd500) / 64'd1000;
  localparam longint unsigned Thr    = ((64'd1 << (2 * FB)) + 64'd5000) / 64'd10000;
  localparam logic [DW-1:0]   MaxD   = DW'(MaxL);
  localparam logic [DW-1:0]   MinD   = ~MaxD;
  localparam logic [DW-1:0]   OneSat = (OneL > MaxL) ? MaxD : DW'(OneL);
  localparam logic signed [RW-1:0] OneR = RW'(OneL);
  localparam logic [QB-1:0]   NegLim = QB'(1) << (DW - 1);

  typedef struct packed {
    rmq_branch_e                br;
    logic [RootW:0]             rem;
    logic [RootW-1:0]           root;
    logic [NW-1:0]              src;
    logic [2:0][DW:0]           num;
    logic [DW-1:0]              dom;
    logic [SW-1:0]              den;
    logic [2:0][SW-1:0]         drem;
    logic [2:0][QB-1:0]         dlo;
    logic [2:0][QB-1:0]         quo;
    logic [2:0]                 ovf;
    logic [2:0]                 neg;
    logic [2:0]                 zero;
    logic [3:0][DW-1:0]         q;
    logic [3:0][2*DW-1:0]       sq;
  } stage_t;

  stage_t       data_q [L];
  stage_t       stage_d [L];
  logic [L-1:0] v_q;
  logic [L-1:0] v_in;
  logic [L:0]   adv;

  // handshake chain
  always_comb begin
    adv[L] = !out_stall_i;
    for (int k = L - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_in = {v_q[L-2:0], in_valid_i};
  end

  assign in_stall_o = !adv[0];

  // front: branch choice, radicand, numerators
  always_comb begin
    logic signed [DW-1:0] a, b, c;
    logic signed [RW-1:0] rad;
    logic [RW-2:0]        radu;
    stage_t               s;
    s = '0;
    if (r0c0_i > r1c1_i && r0c0_i > r2c2_i) begin
      s.br = BR_X;
    end else if (r1c1_i > r2c2_i) begin
      s.br = BR_Y;
    end else begin
      s.br = BR_Z;
    end
    case (s.br)
      BR_X: begin
        a = r0c0_i; b = r1c1_i; c = r2c2_i;
        s.num[0] = (DW+1)'(r0c1_i) + (DW+1)'(r1c0_i);
        s.num[1] = (DW+1)'(r2c0_i) + (DW+1)'(r0c2_i);
        s.num[2] = (DW+1)'(r1c2_i) - (DW+1)'(r2c1_i);
      end
      BR_Y: begin
        a = r1c1_i; b = r0c0_i; c = r2c2_i;
        s.num[0] = (DW+1)'(r0c1_i) + (DW+1)'(r1c0_i);
        s.num[1] = (DW+1)'(r1c2_i) + (DW+1)'(r2c1_i);
        s.num[2] = (DW+1)'(r2c0_i) - (DW+1)'(r0c2_i);
      end
      default: begin
        a = r2c2_i; b = r0c0_i; c = r1c1_i;
        s.num[0] = (DW+1)'(r2c0_i) + (DW+1)'(r0c2_i);
        s.num[1] = (DW+1)'(r1c2_i) + (DW+1)'(r2c1_i);
        s.num[2] = (DW+1)'(r0c1_i) - (DW+1)'(r1c0_i);
      end
    endcase
    rad   = OneR + RW'(a) - RW'(b) - RW'(c);
    radu  = rad[RW-1] ? '0 : rad[RW-2:0];
    s.src = NW'({radu, {FB{1'b0}}});
    stage_d[0] = s;
  end

  for (genvar k = 1; k <= RootW; k++) begin : g_root
    logic [RootW:0]   rem_w;
    logic [RootW-1:0] root_w;
    logic [NW-1:0]    src_w;

    rmq_root_step #(
      .RootW(RootW),
      .NW   (NW)
    ) u_step (
      .rem_i (data_q[k-1].rem),
      .root_i(data_q[k-1].root),
      .src_i (data_q[k-1].src),
      .rem_o (rem_w),
      .root_o(root_w),
      .src_o (src_w)
    );

    always_comb begin
      stage_d[k]      = data_q[k-1];
      stage_d[k].rem  = rem_w;
      stage_d[k].root = root_w;
      stage_d[k].src  = src_w;
    end
  end

  // divisor and dividends
  always_comb begin
    logic [RootW:0]        s2;
    logic [RootW-1:0]      half;
    logic signed [DW+1:0]  ext;
    logic [DW:0]           mag;
    logic [DDW-1:0]        dvd;
    logic [FB-1:0]         hi;
    stage_t                s;
    s    = data_q[Prep-1];
    s2   = {s.root, 1'b0};
    half = s.root >> 1;
    s.dom = (64'(half) > 64'(MaxL)) ? MaxD : DW'(half);
    if (s.br == BR_Z && 64'(s2) < Small) begin
      s.den = SW'(OneL);
    end else begin
      s.den = SW'(s2);
    end
    for (int i = 0; i < 3; i++) begin
      ext       = (DW+2)'($signed(s.num[i]));
      mag       = s.num[i][DW] ? (DW+1)'(0) - ext[DW:0] : ext[DW:0];
      dvd       = {mag, {FB{1'b0}}};
      hi        = dvd[DDW-1:QB];
      s.ovf[i]  = (hi >= s.den);
      s.drem[i] = SW'(hi);
      s.dlo[i]  = dvd[QB-1:0];
      s.quo[i]  = '0;
      s.neg[i]  = s.num[i][DW];
      s.zero[i] = (s.num[i] == '0);
    end
    stage_d[Prep] = s;
  end

  for (genvar k = Prep + 1; k <= DivL; k++) begin : g_div
    logic [2:0][SW-1:0] rem_w;
    logic [2:0][QB-1:0] lo_w;
    logic [2:0][QB-1:0] quo_w;

    for (genvar i = 0; i < 3; i++) begin : g_lane
      rmq_div_step #(
        .SW(SW),
        .QB(QB)
      ) u_step (
        .rem_i(data_q[k-1].drem[i]),
        .lo_i (data_q[k-1].dlo[i]),
        .quo_i(data_q[k-1].quo[i]),
        .den_i(data_q[k-1].den),
        .rem_o(rem_w[i]),
        .lo_o (lo_w[i]),
        .quo_o(quo_w[i])
      );
    end

    always_comb begin
      stage_d[k]      = data_q[k-1];
      stage_d[k].drem = rem_w;
      stage_d[k].dlo  = lo_w;
      stage_d[k].quo  = quo_w;
    end
  end

  // saturation and placement
  always_comb begin
    logic [2:0][DW-1:0] d;
    stage_t             s;
    s = data_q[SatS-1];
    for (int i = 0; i < 3; i++) begin
      if (s.zero[i]) begin
        d[i] = '0;
      end else if (!s.neg[i]) begin
        d[i] = (s.ovf[i] || s.quo[i] > QB'(MaxD)) ? MaxD : s.quo[i][DW-1:0];
      end else begin
        d[i] = (s.ovf[i] || s.quo[i] > NegLim) ? MinD : DW'(0) - s.quo[i][DW-1:0];
      end
    end
    case (s.br)
      BR_X:    s.q = {d[2], d[1], d[0], s.dom};
      BR_Y:    s.q = {d[2], d[1], s.dom, d[0]};
      default: s.q = {d[2], s.dom, d[1], d[0]};
    endcase
    stage_d[SatS] = s;
  end

  always_comb begin
    stage_d[SqS] = data_q[SqS-1];
    for (int j = 0; j < 4; j++) begin
      stage_d[SqS].sq[j] = (2*DW)'($signed(data_q[SqS-1].q[j]) * $signed(data_q[SqS-1].q[j]));
    end
  end

  // tiny norm check
  always_comb begin
    logic [2*DW+1:0] sum;
    sum = '0;
    for (int j = 0; j < 4; j++) begin
      sum = sum + (2*DW+2)'(data_q[Fin-1].sq[j]);
    end
    stage_d[Fin] = data_q[Fin-1];
    if (64'(sum) < Thr) begin
      stage_d[Fin].q[3] = OneSat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < L; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < L; k++) begin
      if (adv[k] && v_in[k]) begin
        data_q[k] <= stage_d[k];
      end
    end
  end

  assign out_valid_o = v_q[L-1];
  assign quat_x_o    = data_q[L-1].q[0];
  assign quat_y_o    = data_q[L-1].q[1];
  assign quat_z_o    = data_q[L-1].q[2];
  assign quat_w_o    = data_q[L-1].q[3];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  a_x_dom_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_q[L-1].br == BR_X |-> !quat_x_o[DW-1])
    else $error("dominant x component negative");

  a_z_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Prep] && data_q[Prep].br == BR_Z |-> data_q[Prep].den != '0)
    else $error("zero divisor in z branch");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[RootW] |-> data_q[RootW].rem <= {data_q[RootW].root, 1'b0})
    else $error("square root remainder out of range");

endmodule

>>> sim/tb.sv
// testbench for rotation_matrix_to_quaternion_unit: directed table then random matrices,
// every result checked against a behavioural predictor of the conversion or a known table value
// depends on rmq_pkg and the unit's rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam longint QMAX = 32767;
  localparam longint QMIN = -32768;
  localparam int LATENCY = 40;
  localparam int LIMIT = 2000000;

  typedef logic signed [DW-1:0] fx_t;
  typedef struct packed { fx_t x, y, z, w; } quat_t;
  typedef struct packed {
    fx_t m00, m10, m20, m01, m11, m21, m02, m12, m22;
  } matrix_t;
  typedef struct { matrix_t m; logic known; quat_t q; } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  matrix_t mat = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fx_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_t expected_quats[$];
  int mismatches = 0;
  int cycles = 0;
  int accepted = 0;
  int received = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_recv = 0;
  int branch_count[3] = '{0, 0, 0};

  always #5 clk_i = ~clk_i;

  rotation_matrix_to_quaternion_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .r0c0_i(mat.m00), .r1c0_i(mat.m10), .r2c0_i(mat.m20),
    .r0c1_i(mat.m01), .r1c1_i(mat.m11), .r2c1_i(mat.m21),
    .r0c2_i(mat.m02), .r1c2_i(mat.m12), .r2c2_i(mat.m22),
    .out_valid_o, .out_stall_i, .quat_x_o, .quat_y_o, .quat_z_o, .quat_w_o
  );

  function automatic longint clip(longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  function automatic longint floor_root(longint n);
    longint r;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n) r += 64'sd1 <<< b;
    end
    return r;
  endfunction

  function automatic longint doubled_root(longint a, longint b, longint c);
    longint r;
    r = ONE + a - b - c;
    if (r < 0) r = 0;
    return 2 * floor_root(r * ONE);
  endfunction

  function automatic longint sat_quotient(longint num, longint den);
    if (den == 0) return num > 0 ? QMAX : (num < 0 ? QMIN : 0);
    return clip((num * ONE) / den);
  endfunction

  function automatic longint bounded_square(longint v, longint cap);
    return v * v < cap ? v * v : cap;
  endfunction

  function automatic quat_t quaternion_of(matrix_t m);
    longint a0, a1, a2, a4, a5, a6, a8, a9, a10, s, qx, qy, qz, qw, thr, sum;
    quat_t q;
    rmq_branch_e br;
    a0 = m.m00; a1 = m.m10; a2 = m.m20; a4 = m.m01; a5 = m.m11;
    a6 = m.m21; a8 = m.m02; a9 = m.m12; a10 = m.m22;
    if (a0 > a5 && a0 > a10) begin
      br = BR_X;
      s = doubled_root(a0, a5, a10);
      qx = clip(s / 4);
      qy = sat_quotient(a4 + a1, s);
      qz = sat_quotient(a2 + a8, s);
      qw = sat_quotient(a9 - a6, s);
    end else if (a5 > a10) begin
      br = BR_Y;
      s = doubled_root(a5, a0, a10);
      qy = clip(s / 4);
      qx = sat_quotient(a4 + a1, s);
      qz = sat_quotient(a9 + a6, s);
      qw = sat_quotient(a2 - a8, s);
    end else begin
      br = BR_Z;
      s = doubled_root(a10, a0, a5);
      qz = clip(s / 4);
      if (s < (ONE + 500) / 1000) s = ONE;
      qx = sat_quotient(a2 + a8, s);
      qy = sat_quotient(a9 + a6, s);
      qw = sat_quotient(a4 - a1, s);
    end
    thr = ((64'sd1 <<< (2 * FB)) + 5000) / 10000;
    sum = bounded_square(qx, thr) + bounded_square(qy, thr)
        + bounded_square(qz, thr) + bounded_square(qw, thr);
    if (sum < thr) qw = clip(ONE);
    branch_count[br]++;
    q.x = fx_t'(qx); q.y = fx_t'(qy); q.z = fx_t'(qz); q.w = fx_t'(qw);
    return q;
  endfunction

  function automatic fx_t pick_element();
    case ($urandom_range(0, 7))
      0: return fx_t'(16'h8000);
      1: return fx_t'(16'h7fff);
      2: return fx_t'(ONE);
      3: return fx_t'(-ONE);
      4: return fx_t'($urandom_range(0, 64)) - fx_t'(32);
      5: return fx_t'($urandom);
      default: return fx_t'($urandom_range(0, 2 * ONE)) - fx_t'(ONE);
    endcase
  endfunction

  // mostly matrices of special and random picked elements, the rest random bits
  function automatic matrix_t random_matrix();
    matrix_t m;
    if ($urandom_range(0, 3) == 0) begin
      m = $bits(matrix_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      m.m00 = pick_element(); m.m10 = pick_element(); m.m20 = pick_element();
      m.m01 = pick_element(); m.m11 = pick_element(); m.m21 = pick_element();
      m.m02 = pick_element(); m.m12 = pick_element(); m.m22 = pick_element();
    end
    return m;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result checking at the rising edge
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{quat_x_o, quat_y_o, quat_z_o, quat_w_o};
      received++;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", got);
      end else begin
        want = expected_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                     want.x, want.y, want.z, want.w, got.x, got.y, got.z, got.w);
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_recv > 0) begin
      out_stall_i <= 1'b1;
      hold_recv <= hold_recv - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic send(matrix_t m, quat_t q);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mat <= m;
    expected_quats.push_back(q);
    do @(posedge clk_i); while (in_stall_o);
    accepted++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    matrix_t m;
    quat_t q;

    // identity, its negation, extremes, tiny norm, zero divisor and small root in z branch
    r.known = 1'b1;
    r.m = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
    r.q = '{0, 0, 0, 16'sd16384}; rows.push_back(r);
    r.m = '0; r.q = '{0, 0, 16'sd8192, 0}; rows.push_back(r);
    r.known = 1'b0;
    r.m = '{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384}; rows.push_back(r);
    r.m = '{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, -16'sd16384}; rows.push_back(r);
    r.m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384}; rows.push_back(r);
    r.m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384}; rows.push_back(r);
    r.m = {9{16'h8000}}; rows.push_back(r);
    r.m = {9{16'h7fff}}; rows.push_back(r);
    r.m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh7fff, 16'sh8000}; rows.push_back(r);
    r.m = '{16'sd10, 16'sh7fff, 16'sh8000, 16'sh7fff, -16'sh7fff, 16'sh7fff,
            16'sh8000, 16'sh8000, -16'sh7fff}; rows.push_back(r);
    r.m = '{16'sd10, 16'sh7fff, 16'sd5, 16'sd3, 16'sh8000, 16'sh8000,
            16'sd4, 16'sh7fff, 16'sd9}; rows.push_back(r);
    r.m = '{16'sh7fff, -16'sd5, 16'sd5, 16'sd7, 16'sh7fff, -16'sd7,
            16'sd0, 16'sd0, 16'sh7fff}; rows.push_back(r);
    r.m = '{16'sh7000, 16'sd0, 16'sd1, 16'sd0, 16'sh7000, 16'sd0,
            -16'sd1, 16'sd0, 16'sh7000}; rows.push_back(r);
    r.m = '{16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd0, 16'sd4,
            16'sd5, 16'sd6, 16'sd8192}; rows.push_back(r);
    r.m = '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
            16'sd0, 16'sd0, 16'sd16384}; rows.push_back(r);
    r.m = '{16'sd5, 16'sd1, 16'sd1, 16'sd1, 16'sd5, 16'sd1,
            16'sd1, 16'sd1, 16'sd5}; rows.push_back(r);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      q = quaternion_of(rows[i].m);
      send(rows[i].m, rows[i].known ? rows[i].q : q);
    end
    drain();

    // long receiver hold-off while matrices keep coming
    hold_recv <= 200;
    for (int i = 0; i < 100; i++) begin
      m = random_matrix();
      send(m, quaternion_of(m));
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 32 : (phase == 1 ? 76 : 0);
      recv_idle = phase == 0 ? 76 : (phase == 1 ? 32 : 0);
      for (int i = 0; i < 510; i++) begin
        m = random_matrix();
        send(m, quaternion_of(m));
        if (i == 255) drain();
      end
      drain();
    end

    repeat (LATENCY) @(negedge clk_i);
    $display("%0d matrices sent, %0d quaternions checked", accepted, received);
    $display("branches x/y/z: %0d/%0d/%0d, %0d mismatches",
             branch_count[0], branch_count[1], branch_count[2], mismatches);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/rmq_pkg.sv
design/rmq_root_step.sv
design/rmq_div_step.sv
design/rotation_matrix_to_quaternion_unit.sv
sim/tb.sv
